// ===== sv/idle_fade_level_controller_core_defines.svh =====
// Assertion macros for the idle fade level controller.
// Included by the top level only; needs nothing else.
`ifndef IDLE_FADE_LEVEL_CONTROLLER_CORE_DEFINES_SVH
`define IDLE_FADE_LEVEL_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define IFLC_AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("iflc check failed");

// next-cycle implication
`define IFLC_AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("iflc check failed");

`endif

// ===== sv/iflc_pkg.sv =====
// Shared types and constants of the idle fade level controller.
// No dependencies.
`default_nettype none

package iflc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR = 3'd4;

    typedef struct packed {
        logic               req_type;
        logic               activity_ok;
        logic               tracked_present;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]         base_alpha;
    } t_in_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_UPD,
        S_FADE,
        S_EFF,
        S_EMUL,
        S_ECAP,
        S_AMUL,
        S_PUSH
    } t_state;

    typedef enum logic [2:0] {
        MUL_SQX,
        MUL_SQY,
        MUL_SQZ,
        MUL_FF,
        MUL_EASE,
        MUL_ALPHA
    } t_mul_sel;

    typedef struct packed {
        logic     load_item;
        t_mul_sel mul_sel;
        logic     sum_load;
        logic     sum_acc;
        logic     upd_track;
        logic     upd_fade;
        logic     load_eased;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic is_scale;
        logic enabled;
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/iflc_in_if.sv =====
// Input channel of the idle fade level controller: valid, ready, request item.
// Depends on iflc_pkg.
`default_nettype none

interface iflc_in_if;
    import iflc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/iflc_out_if.sv =====
// Result channel of the idle fade level controller: valid, ready, result fields.
// Level width follows the fraction width of the fade level.
`default_nettype none

interface iflc_out_if #(
    parameter int LVL_W = 17
);
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] fade_level;
    logic [LVL_W-1:0] eased_level;
    logic [7:0]       scaled_alpha;
    logic             full_visible;

    modport source (output valid, output fade_level, output eased_level,
                    output scaled_alpha, output full_visible, input ready);
    modport sink   (input valid, input fade_level, input eased_level,
                    input scaled_alpha, input full_visible, output ready);
endinterface

`default_nettype wire

// ===== sv/iflc_ctrl.sv =====
// Sequencer of the idle fade level controller: steps the shared multiplier
// through tick and easing phases and owns the channel handshakes. Uses iflc_pkg.
`default_nettype none

module iflc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    input  wire iflc_pkg::t_stat i_stat,
    output iflc_pkg::t_cmd       o_cmd
);
    import iflc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && !i_out_ready;
        o_cmd     = '0;
        o_cmd.mul_sel = MUL_ALPHA;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_state = i_stat.is_scale ? S_EFF : S_SQX;
            end
            S_SQX: begin
                o_cmd.mul_sel = MUL_SQX;
                n_state = S_SQY;
            end
            S_SQY: begin
                o_cmd.mul_sel  = MUL_SQY;
                o_cmd.sum_load = 1'b1;
                n_state = S_SQZ;
            end
            S_SQZ: begin
                o_cmd.mul_sel = MUL_SQZ;
                o_cmd.sum_acc = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_track = 1'b1;
                n_state = i_stat.enabled ? S_FADE : S_EFF;
            end
            S_FADE: begin
                o_cmd.upd_fade = 1'b1;
                n_state = S_EFF;
            end
            S_EFF: begin
                o_cmd.mul_sel = MUL_FF;
                n_state = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.mul_sel = MUL_EASE;
                n_state = S_ECAP;
            end
            S_ECAP: begin
                o_cmd.load_eased = 1'b1;
                n_state = S_AMUL;
            end
            S_AMUL: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                // product stays on base * eased while the result register is busy
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

// ===== sv/iflc_dp.sv =====
// Datapath of the idle fade level controller: configuration registers, tracking
// and fade state, shared multiplier and result register. Uses iflc_pkg.
`default_nettype none

module iflc_dp #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 16,
    parameter int LVL_W       = FRAC_BITS + 1
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [iflc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [iflc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire  iflc_pkg::t_cmd               i_cmd,
    output iflc_pkg::t_stat                    o_stat,
    input  wire  iflc_pkg::t_in_item           i_item,
    output logic [LVL_W-1:0]                   o_fade_level,
    output logic [LVL_W-1:0]                   o_eased_level,
    output logic [7:0]                         o_scaled_alpha,
    output logic                               o_full_visible
);
    import iflc_pkg::*;

    localparam int MUL_W = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int SW    = (LVL_W > 16) ? LVL_W : 16;

    localparam logic [63:0] ONE64  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] SMAX64 = (2 * ONE64 + 64'd2) / 64'd3;
    localparam logic [63:0] FULL64 = (64'd999 * ONE64 + 64'd999) / 64'd1000;
    localparam logic [63:0] K3_64  = 3 * ONE64;

    localparam logic [LVL_W-1:0] ONE         = ONE64[LVL_W-1:0];
    localparam logic [LVL_W-1:0] FULL_THRESH = FULL64[LVL_W-1:0];
    localparam logic [SW-1:0]    STEP_MAX    = SMAX64[SW-1:0];
    localparam logic [LVL_W:0]   K3          = K3_64[LVL_W:0];

    // configuration
    logic             r_enable;
    logic [15:0]      r_limit;
    logic [15:0]      r_step;
    logic [LVL_W-1:0] r_rest;
    logic [31:0]      r_thr;

    // state
    logic [LVL_W-1:0]       r_fade;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [31:0]            r_last [3];
    logic                   r_last_vld;

    // work registers
    t_in_item           r_item;
    logic [2*MUL_W-1:0] r_prod;
    logic [33:0]        r_sum;
    logic [LVL_W-1:0]   r_eased;

    logic [LVL_W-1:0] r_o_fade;
    logic [LVL_W-1:0] r_o_eased;
    logic [7:0]       r_o_alpha;
    logic             r_o_full;

    logic [31:0]      w_pos [3];
    logic [32:0]      w_d   [3];
    logic [32:0]      w_mag [3];
    logic             w_large;
    logic [33:0]      w_sum_all;
    logic             w_tracked;
    logic             w_moved;
    logic [MUL_W-1:0] w_mul_a, w_mul_b;
    logic [LVL_W-1:0] w_f2;
    logic [LVL_W:0]   w_k;
    logic [LVL_W:0]   w_e_raw;
    logic [LVL_W-1:0] w_rest_c;
    logic [LVL_W-1:0] w_target;
    logic [SW-1:0]    w_step_ext;
    logic [LVL_W-1:0] w_step;
    logic [LVL_W-1:0] w_fade_nxt;
    logic             w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_limit  <= 16'd240;
            r_step   <= 16'd1820;
            r_rest   <= '0;
            r_thr    <= 32'd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:     r_enable <= i_cfg_data[0];
                CFG_IDLE_LIMIT: r_limit  <= i_cfg_data[15:0];
                CFG_FADE_STEP:  r_step   <= i_cfg_data[15:0];
                CFG_REST_LEVEL: r_rest   <= i_cfg_data[LVL_W-1:0];
                CFG_MOTION_THR: r_thr    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // position deltas against the stored position
    always_comb begin
        w_pos[0] = r_item.pos_x;
        w_pos[1] = r_item.pos_y;
        w_pos[2] = r_item.pos_z;
        w_large  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_d[i]   = {w_pos[i][31], w_pos[i]} - {r_last[i][31], r_last[i]};
            w_mag[i] = w_d[i][32] ? (~w_d[i] + 33'd1) : w_d[i];
            w_large  = w_large | (|w_mag[i][32:16]);
        end
    end

    assign w_sum_all = r_sum + {2'b00, r_prod[31:0]};
    assign w_tracked = r_item.activity_ok && r_item.tracked_present;
    assign w_moved   = w_tracked && r_last_vld && (w_large || (w_sum_all > {2'b00, r_thr}));

    // shared multiplier operands
    assign w_f2 = r_prod[FRAC_BITS +: LVL_W];
    assign w_k  = K3 - {r_fade, 1'b0};

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SQX: begin
                w_mul_a = MUL_W'(w_mag[0][15:0]);
                w_mul_b = MUL_W'(w_mag[0][15:0]);
            end
            MUL_SQY: begin
                w_mul_a = MUL_W'(w_mag[1][15:0]);
                w_mul_b = MUL_W'(w_mag[1][15:0]);
            end
            MUL_SQZ: begin
                w_mul_a = MUL_W'(w_mag[2][15:0]);
                w_mul_b = MUL_W'(w_mag[2][15:0]);
            end
            MUL_FF: begin
                w_mul_a = MUL_W'(r_fade);
                w_mul_b = MUL_W'(r_fade);
            end
            MUL_EASE: begin
                w_mul_a = MUL_W'(w_f2);
                w_mul_b = MUL_W'(w_k);
            end
            MUL_ALPHA: begin
                w_mul_a = MUL_W'(r_item.base_alpha);
                w_mul_b = MUL_W'(r_eased);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_e_raw = r_prod[FRAC_BITS +: LVL_W+1];

    // slew toward the target level
    always_comb begin
        w_rest_c   = (r_rest > ONE) ? ONE : r_rest;
        w_target   = (CMP_W'(r_count) >= CMP_W'(r_limit)) ? w_rest_c : ONE;
        w_step_ext = SW'(r_step);
        if (r_step == 16'd0) begin
            w_step = LVL_W'(1);
        end else if (w_step_ext > STEP_MAX) begin
            w_step = STEP_MAX[LVL_W-1:0];
        end else begin
            w_step = w_step_ext[LVL_W-1:0];
        end
        if (r_fade < w_target) begin
            w_fade_nxt = ((w_target - r_fade) < w_step) ? w_target : r_fade + w_step;
        end else if (r_fade > w_target) begin
            w_fade_nxt = ((r_fade - w_target) < w_step) ? w_target : r_fade - w_step;
        end else begin
            w_fade_nxt = r_fade;
        end
    end

    assign w_full = !r_enable || (r_eased >= FULL_THRESH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade     <= ONE;
            r_count    <= '0;
            r_last_vld <= 1'b0;
        end else begin
            if (i_cmd.upd_track) begin
                if (!r_enable) begin
                    r_fade     <= ONE;
                    r_count    <= '0;
                    r_last_vld <= 1'b0;
                end else begin
                    r_last_vld <= w_tracked;
                    if (!r_item.activity_ok || w_moved) begin
                        r_count <= '0;
                    end else if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
            if (i_cmd.upd_fade) begin
                r_fade <= w_fade_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.sum_load) begin
            r_sum <= {2'b00, r_prod[31:0]};
        end else if (i_cmd.sum_acc) begin
            r_sum <= w_sum_all;
        end
        if (i_cmd.upd_track && r_enable && w_tracked) begin
            for (int i = 0; i < 3; i++) begin
                r_last[i] <= w_pos[i];
            end
        end
        if (i_cmd.load_eased) begin
            r_eased <= (w_e_raw > {1'b0, ONE}) ? ONE : w_e_raw[LVL_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_o_fade  <= r_fade;
            r_o_eased <= r_eased;
            r_o_full  <= w_full;
            r_o_alpha <= w_full ? r_item.base_alpha : r_prod[FRAC_BITS +: 8];
        end
    end

    assign o_stat.is_scale = r_item.req_type;
    assign o_stat.enabled  = r_enable;

    assign o_fade_level   = r_o_fade;
    assign o_eased_level  = r_o_eased;
    assign o_scaled_alpha = r_o_alpha;
    assign o_full_visible = r_o_full;

endmodule

`default_nettype wire

// ===== sv/idle_fade_level_controller_core.sv =====
// Idle fade level controller, top level: sequencer plus datapath.
// Tick request: delta squares, tracking update, fade slew (skipped when disabled),
// easing, alpha scaling; a scale request skips to easing. One request at a time.
// The single shared multiplier steps squares and easing; a full result register stalls.
// Synchronous active-low reset: fade full, idle count zero, tracking invalid,
// registers at defaults; no clearing pass.
`default_nettype none
`include "idle_fade_level_controller_core_defines.svh"

module idle_fade_level_controller_core #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    iflc_in_if.sink                         i_in,
    iflc_out_if.source                      o_out,
    input  wire                             i_cfg_we,
    input  wire [iflc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [iflc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import iflc_pkg::*;

    localparam int LVL_W = FRAC_BITS + 1;
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << FRAC_BITS;

    t_cmd  w_cmd;
    t_stat w_stat;

    iflc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    iflc_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .LVL_W       (LVL_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_item         (i_in.payload),
        .o_fade_level   (o_out.fade_level),
        .o_eased_level  (o_out.eased_level),
        .o_scaled_alpha (o_out.scaled_alpha),
        .o_full_visible (o_out.full_visible)
    );

    // one transaction in flight: no second acceptance right after one
    `IFLC_AST_NXT(a_single_item, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // levels never exceed full scale
    `IFLC_AST_IMP(a_level_range, i_clk, i_rst_n, o_out.valid, (o_out.fade_level <= LVL_ONE) && (o_out.eased_level <= LVL_ONE))
    // a full eased level is always reported fully visible
    `IFLC_AST_IMP(a_full_flag, i_clk, i_rst_n, o_out.valid && (o_out.eased_level == LVL_ONE), o_out.full_visible)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for idle_fade_level_controller_core: a scoreboard class
// tracks fade, idle count and tracking state and checks every result.
// Depends on iflc_pkg, iflc_in_if, iflc_out_if and the core.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iflc_pkg::*;

    localparam int              CLK_PERIOD     = 10;
    localparam int              FRAC           = 16;
    localparam int              LVL_W          = FRAC + 1;
    localparam longint unsigned LVL_ONE        = 64'd1 << FRAC;
    localparam longint unsigned STEP_CAP       = (2 * LVL_ONE + 2) / 3;
    localparam longint unsigned FULL_THR       = (999 * LVL_ONE + 999) / 1000;
    localparam longint unsigned COUNT_SAT      = 64'hFFFF;
    localparam logic            REQ_TICK       = 1'b0;
    localparam logic            REQ_SCALE      = 1'b1;
    localparam int              DRAIN_SLACK    = 16;
    localparam int              HOLD_CYCLES    = 400;
    localparam int              WATCHDOG_LIMIT = 3000;
    localparam int              CHUNK_ITEMS    = 100;
    localparam int              SOAK_TICKS     = 40;

    typedef struct packed {
        logic [LVL_W-1:0] fade_level;
        logic [LVL_W-1:0] eased_level;
        logic [7:0]       scaled_alpha;
        logic             full_visible;
    } level_result_t;

    class fade_scoreboard;
        bit              en;
        logic [15:0]     limit_ticks;
        logic [15:0]     step_raw;
        logic [16:0]     rest_raw;
        logic [31:0]     thr_sq;
        longint unsigned fade;
        longint unsigned idle_cnt;
        longint          last_pos [3];
        bit              track_valid;
        level_result_t   levels_due [$];
        int unsigned     mismatches;

        function new();
            en          = 1'b1;
            limit_ticks = 16'd240;
            step_raw    = 16'd1820;
            rest_raw    = '0;
            thr_sq      = 32'd16384;
            fade        = LVL_ONE;
            idle_cnt    = 0;
            last_pos    = '{0, 0, 0};
            track_valid = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ENABLE:     en = data[0];
                CFG_IDLE_LIMIT: limit_ticks = data[15:0];
                CFG_FADE_STEP:  step_raw = data[15:0];
                CFG_REST_LEVEL: rest_raw = data[16:0];
                CFG_MOTION_THR: thr_sq = data;
                default: ;
            endcase
        endfunction

        function longint unsigned smoothstep(longint unsigned f);
            longint unsigned f2, e;
            if (f > LVL_ONE) f = LVL_ONE;
            f2 = (f * f) >> FRAC;
            e  = (f2 * (3 * LVL_ONE - 2 * f)) >> FRAC;
            return (e > LVL_ONE) ? LVL_ONE : e;
        endfunction

        function bit position_jumped(longint px, longint py, longint pz);
            longint          cur [3];
            longint          d;
            longint unsigned a, sum;
            cur = '{px, py, pz};
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                d = cur[i] - last_pos[i];
                a = (d < 0) ? -d : d;
                // an axis step this large squares past any 32-bit threshold
                if (a > 64'hFFFF) return 1'b1;
                sum += a * a;
            end
            return sum > thr_sq;
        endfunction

        function void advance_tick(t_in_item it);
            longint          px, py, pz;
            bit              moved;
            longint unsigned target, step, rest;
            moved = 1'b0;
            if (!en) begin
                fade        = LVL_ONE;
                idle_cnt    = 0;
                track_valid = 1'b0;
                return;
            end
            if (it.activity_ok && it.tracked_present) begin
                px = longint'($signed(it.pos_x));
                py = longint'($signed(it.pos_y));
                pz = longint'($signed(it.pos_z));
                if (track_valid) moved = position_jumped(px, py, pz);
                last_pos    = '{px, py, pz};
                track_valid = 1'b1;
            end else begin
                track_valid = 1'b0;
            end
            if (!it.activity_ok || moved) idle_cnt = 0;
            else if (idle_cnt < COUNT_SAT) idle_cnt++;
            rest   = (rest_raw > LVL_ONE) ? LVL_ONE : rest_raw;
            target = (idle_cnt >= limit_ticks) ? rest : LVL_ONE;
            step   = (step_raw == 0) ? 1 : step_raw;
            if (step > STEP_CAP) step = STEP_CAP;
            if (fade < target) fade = (target - fade < step) ? target : fade + step;
            else if (fade > target) fade = (fade - target < step) ? target : fade - step;
        endfunction

        function void note_request(t_in_item it);
            longint unsigned eased;
            bit              full;
            level_result_t   r;
            if (it.req_type == REQ_TICK) advance_tick(it);
            eased          = smoothstep(fade);
            full           = !en || eased >= FULL_THR;
            r.fade_level   = fade[LVL_W-1:0];
            r.eased_level  = eased[LVL_W-1:0];
            r.scaled_alpha = full ? it.base_alpha : 8'((64'(it.base_alpha) * eased) >> FRAC);
            r.full_visible = full;
            levels_due.insert(levels_due.size(), r);
        endfunction

        function void check_result(level_result_t got);
            level_result_t exp_r;
            if (levels_due.size() == 0) begin
                $error("result with none pending: fade_level %0d", got.fade_level);
                mismatches++;
                return;
            end
            exp_r = levels_due.pop_front();
            if (got.fade_level !== exp_r.fade_level) begin
                $error("fade_level: expected %0d, got %0d", exp_r.fade_level, got.fade_level);
                mismatches++;
            end
            if (got.eased_level !== exp_r.eased_level) begin
                $error("eased_level: expected %0d, got %0d", exp_r.eased_level, got.eased_level);
                mismatches++;
            end
            if (got.scaled_alpha !== exp_r.scaled_alpha) begin
                $error("scaled_alpha: expected %0d, got %0d",
                       exp_r.scaled_alpha, got.scaled_alpha);
                mismatches++;
            end
            if (got.full_visible !== exp_r.full_visible) begin
                $error("full_visible: expected %0d, got %0d",
                       exp_r.full_visible, got.full_visible);
                mismatches++;
            end
        endfunction

        function int pending();
            return levels_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    iflc_in_if                    in_ch ();
    iflc_out_if #(.LVL_W(LVL_W))  out_ch ();

    idle_fade_level_controller_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    fade_scoreboard sb;
    int unsigned    tx_idle_pct;
    int unsigned    rx_idle_pct;
    logic           hold_req;
    logic           hold_seen;
    int unsigned    hold_left;
    int unsigned    quiet_cycles;
    logic [31:0]    walk_pos [3];

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        hold_req = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        walk_pos = '{default: '0};
    end

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result side: random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.payload);
            if (out_ch.valid && out_ch.ready)
                sb.check_result('{out_ch.fade_level, out_ch.eased_level,
                                  out_ch.scaled_alpha, out_ch.full_visible});
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic t_in_item tick_req(bit act, bit trk, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
        t_in_item it;
        it.req_type        = REQ_TICK;
        it.activity_ok     = act;
        it.tracked_present = trk;
        it.pos_x           = x;
        it.pos_y           = y;
        it.pos_z           = z;
        it.base_alpha      = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item scale_req(logic [7:0] alpha);
        t_in_item it;
        it.req_type        = REQ_SCALE;
        it.activity_ok     = 1'($urandom);
        it.tracked_present = 1'($urandom);
        it.pos_x           = $urandom;
        it.pos_y           = $urandom;
        it.pos_z           = $urandom;
        it.base_alpha      = alpha;
        return it;
    endfunction

    // mostly a wandering object with small, still or large steps; some noise
    function automatic t_in_item random_req();
        t_in_item    it;
        int unsigned mode;
        int          step_v;
        it = scale_req(8'($urandom));
        it.activity_ok     = ($urandom_range(99) < 85);
        it.tracked_present = ($urandom_range(99) < 85);
        if ($urandom_range(99) < 75) it.req_type = REQ_TICK;
        if (it.req_type == REQ_TICK && it.activity_ok && it.tracked_present) begin
            mode = $urandom_range(99);
            for (int i = 0; i < 3; i++) begin
                if (mode < 30) begin
                    step_v = 0;
                end else if (mode < 80) begin
                    step_v = int'($urandom_range(360)) - 180;
                end else if (mode < 90) begin
                    step_v = int'($urandom_range(131070)) - 65535;
                end else if (mode < 95) begin
                    step_v = $urandom_range(1) ? 65535 : 65536;
                    if ($urandom_range(1)) step_v = -step_v;
                end else begin
                    step_v = $urandom;
                end
                walk_pos[i] = walk_pos[i] + 32'(step_v);
            end
            it.pos_x = walk_pos[0];
            it.pos_y = walk_pos[1];
            it.pos_z = walk_pos[2];
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic random_config();
        logic [31:0] v;
        case ($urandom_range(5))
            0:       v = 0;
            1:       v = 65535;
            2:       v = $urandom_range(65535);
            default: v = $urandom_range(12);
        endcase
        cfg_write(CFG_IDLE_LIMIT, v);
        case ($urandom_range(5))
            0:       v = 0;
            1:       v = 32'(STEP_CAP);
            2:       v = 65535;
            3:       v = $urandom_range(1, 400);
            default: v = $urandom_range(1, 8000);
        endcase
        cfg_write(CFG_FADE_STEP, v);
        case ($urandom_range(4))
            0:       v = 0;
            1:       v = 32'(LVL_ONE);
            2:       v = $urandom_range(LVL_ONE + 1, 131071);
            default: v = $urandom_range(LVL_ONE);
        endcase
        cfg_write(CFG_REST_LEVEL, v);
        case ($urandom_range(4))
            0:       v = 0;
            1:       v = 32'hFFFF_FFFF;
            2:       v = $urandom;
            default: v = $urandom_range(70000);
        endcase
        cfg_write(CFG_MOTION_THR, v);
        cfg_write(CFG_ENABLE, ($urandom_range(5) != 0));
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, flag combinations, extreme positions
        send_item(scale_req(8'hFF));
        send_item(scale_req(8'h00));
        send_item(tick_req(1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_item(tick_req(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        send_item(tick_req(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        send_item(tick_req(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        wait_drained();

        // fastest fade, widest threshold: step size limits of the motion test
        cfg_write(CFG_IDLE_LIMIT, 1);
        cfg_write(CFG_FADE_STEP, 16'hFFFF);
        cfg_write(CFG_REST_LEVEL, 0);
        cfg_write(CFG_MOTION_THR, 32'hFFFF_FFFF);
        send_item(tick_req(1'b1, 1'b1, 32'd0, 32'd0, 32'd0));
        send_item(tick_req(1'b1, 1'b1, 32'd65535, 32'd0, 32'd0));
        send_item(scale_req(8'hFF));
        send_item(tick_req(1'b1, 1'b1, 32'd65535, 32'd65535, 32'd65535));
        send_item(tick_req(1'b1, 1'b1, 32'd65535, 32'd65535, 32'd65535));
        send_item(tick_req(1'b1, 1'b1, 32'd65535, 32'd65535, 32'd65535));
        send_item(scale_req(8'd200));
        wait_drained();

        // zero step, rest above full, sum exactly at then just over threshold
        cfg_write(CFG_FADE_STEP, 0);
        cfg_write(CFG_REST_LEVEL, 17'h1FFFF);
        cfg_write(CFG_MOTION_THR, 32'd16384);
        send_item(tick_req(1'b1, 1'b1, 32'd65663, 32'd65535, 32'd65535));
        send_item(tick_req(1'b1, 1'b1, 32'd65791, 32'd65536, 32'd65535));
        send_item(scale_req(8'hFF));
        wait_drained();

        cfg_write(CFG_ENABLE, 0);
        send_item(tick_req(1'b1, 1'b1, 32'd5, 32'd6, 32'd7));
        send_item(scale_req(8'd77));
        wait_drained();

        cfg_write(CFG_ENABLE, 1);
        cfg_write(CFG_FADE_STEP, 32'(STEP_CAP));
        cfg_write(CFG_REST_LEVEL, 32'(LVL_ONE));
        cfg_write(CFG_IDLE_LIMIT, 0);
        send_item(tick_req(1'b0, 1'b0, 32'd0, 32'd0, 32'd0));
        wait_drained();
        cfg_write(CFG_REST_LEVEL, 32'(LVL_ONE / 2));
        send_item(tick_req(1'b0, 1'b1, 32'd0, 32'd0, 32'd0));
        send_item(scale_req(8'hFF));
        send_item(tick_req(1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
        wait_drained();

        // idle run with the limit at its maximum; target stays full
        cfg_write(CFG_IDLE_LIMIT, 16'hFFFF);
        cfg_write(CFG_REST_LEVEL, 0);
        send_item(tick_req(1'b0, 1'b0, 32'd0, 32'd0, 32'd0));
        for (int n = 0; n < SOAK_TICKS; n++)
            send_item(tick_req(1'b1, 1'b0, $urandom, $urandom, $urandom));

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 51 : 0;
            rx_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 38 : 0;
            for (int chunk = 0; chunk < 4; chunk++) begin
                wait_drained();
                random_config();
                if (phase == 2 && chunk == 0) hold_req <= ~hold_req;
                for (int n = 0; n < CHUNK_ITEMS; n++)
                    send_item(random_req());
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/iflc_pkg.sv
sv/iflc_in_if.sv
sv/iflc_out_if.sv
sv/iflc_ctrl.sv
sv/iflc_dp.sv
sv/idle_fade_level_controller_core.sv
tb/testbench.sv
